// ===== design/name_charset_classifier_defines.svh =====
// Assertion macros used by the name charset classifier checker.
`ifndef NAME_CHARSET_CLASSIFIER_DEFINES_SVH
`define NAME_CHARSET_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NCC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ncc_pkg.sv =====
// Types and constants for the name charset classifier.
package ncc_pkg;

   // Byte values that bound or break the character sets.
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_TILDE = 8'h7E;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] BYTE_NBSP  = 8'hA0;
   localparam logic [7:0] BYTE_C0    = 8'hC0;
   localparam logic [7:0] BYTE_C1    = 8'hC1;
   localparam logic [7:0] BYTE_F5    = 8'hF5;
   localparam logic [7:0] BYTE_81    = 8'h81;
   localparam logic [7:0] BYTE_8D    = 8'h8D;
   localparam logic [7:0] BYTE_8F    = 8'h8F;
   localparam logic [7:0] BYTE_90    = 8'h90;
   localparam logic [7:0] BYTE_9D    = 8'h9D;

   // Priority class of a complete name.
   typedef enum logic [1:0] {
      CLASS_ASCII  = 2'd0,
      CLASS_UTF8   = 2'd1,
      CLASS_LATIN1 = 2'd2,
      CLASS_OTHER  = 2'd3
   } name_class_type;

   // Per-byte verdicts from the decoder.
   typedef struct packed {
      logic       printable;   // 0x20..0x7E
      logic       latin1_ok;
      logic       cp1252_ok;
      logic       utf8_banned; // C0, C1, F5 and above
      logic       utf8_cont;   // 10xxxxxx
      logic [1:0] lead_len;    // continuation bytes a lead byte asks for
   } byte_class_type;

   // One result item, laid out as it sits in the low bits of the result data.
   typedef struct packed {
      name_class_type name_class;
      logic           cp1252_ok;
      logic           latin1_ok;
      logic           utf8_ok;
      logic           ascii_ok;
   } result_type;

endpackage

// ===== design/ncc_byte_decode.sv =====
// Per-byte decoder: tests one byte against each character set.
module ncc_byte_decode import ncc_pkg::*; (
   input  logic [7:0]     name_byte,
   output byte_class_type byte_class
);

   // Set membership tests and the lead byte length, all in parallel.
   always_comb begin
      byte_class.printable   = (name_byte >= BYTE_SPACE) && (name_byte <= BYTE_TILDE);
      byte_class.latin1_ok   = (name_byte >= BYTE_SPACE) &&
                               !(name_byte inside {[BYTE_DEL:BYTE_NBSP]});
      byte_class.cp1252_ok   = (name_byte >= BYTE_SPACE) &&
                               !(name_byte inside {BYTE_DEL, BYTE_81, BYTE_8D,
                                                   BYTE_8F, BYTE_90, BYTE_9D});
      byte_class.utf8_banned = (name_byte inside {BYTE_C0, BYTE_C1}) ||
                               (name_byte >= BYTE_F5);
      byte_class.utf8_cont   = (name_byte[7:6] == 2'b10);
      // Lead byte length: 11110xxx, 1110xxxx and 110xxxxx.
      if (name_byte[7:3] == 5'b11110) begin
         byte_class.lead_len = 2'd3;
      end else if (name_byte[7:4] == 4'b1110) begin
         byte_class.lead_len = 2'd2;
      end else if (name_byte[7:5] == 3'b110) begin
         byte_class.lead_len = 2'd1;
      end else begin
         byte_class.lead_len = 2'd0;
      end
   end

endmodule

// ===== design/ncc_track.sv =====
// Running verdicts for the name in progress and the result for its last byte.
module ncc_track import ncc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_valid,
   input  logic           step_last,
   input  byte_class_type byte_class,
   output result_type     result
);

   logic       ascii_good_ff, ascii_good_in;
   logic       utf8_good_ff, utf8_good_in;
   logic       latin1_good_ff, latin1_good_in;
   logic       cp1252_good_ff, cp1252_good_in;
   logic [1:0] cont_left_ff, cont_left_in;
   logic       utf8_done;

   // Simple sets only ever drop to zero within a name.
   assign ascii_good_in  = ascii_good_ff & byte_class.printable;
   assign latin1_good_in = latin1_good_ff & byte_class.latin1_ok;
   assign cp1252_good_in = cp1252_good_ff & byte_class.cp1252_ok;

   // UTF-8 sequence check; a failure holds until the end of the name.
   always_comb begin
      utf8_good_in = utf8_good_ff;
      cont_left_in = cont_left_ff;
      if (utf8_good_ff) begin
         if (byte_class.utf8_banned) begin
            utf8_good_in = 1'b0;
            cont_left_in = 2'd0;
         end else if (cont_left_ff != 2'd0) begin
            if (byte_class.utf8_cont) begin
               cont_left_in = cont_left_ff - 2'd1;
            end else begin
               utf8_good_in = 1'b0;
               cont_left_in = 2'd0;
            end
         end else if (!byte_class.printable) begin
            if (byte_class.lead_len != 2'd0) begin
               cont_left_in = byte_class.lead_len;
            end else begin
               utf8_good_in = 1'b0;
            end
         end
      end
   end

   // The name is valid UTF-8 only if no continuation bytes are still owed.
   assign utf8_done = utf8_good_in && (cont_left_in == 2'd0);

   // Result fields with first-match priority for the class.
   always_comb begin
      result.ascii_ok  = ascii_good_in;
      result.utf8_ok   = utf8_done;
      result.latin1_ok = latin1_good_in;
      result.cp1252_ok = cp1252_good_in;
      if (ascii_good_in) begin
         result.name_class = CLASS_ASCII;
      end else if (utf8_done) begin
         result.name_class = CLASS_UTF8;
      end else if (latin1_good_in) begin
         result.name_class = CLASS_LATIN1;
      end else begin
         result.name_class = CLASS_OTHER;
      end
   end

   // State update; the last byte of a name starts the next one fresh.
   always_ff @(posedge clock) begin
      if (reset || (step_valid && step_last)) begin
         ascii_good_ff  <= 1'b1;
         utf8_good_ff   <= 1'b1;
         latin1_good_ff <= 1'b1;
         cp1252_good_ff <= 1'b1;
         cont_left_ff   <= 2'd0;
      end else if (step_valid) begin
         ascii_good_ff  <= ascii_good_in;
         utf8_good_ff   <= utf8_good_in;
         latin1_good_ff <= latin1_good_in;
         cp1252_good_ff <= cp1252_good_in;
         cont_left_ff   <= cont_left_in;
      end
   end

endmodule

// ===== design/name_charset_classifier.sv =====
// A last byte passes the input register, then its result waits in the result register.
// Throughput: one byte per cycle; the input register drains whenever its
// byte is not a last byte or the result register is free or being taken.
// Reset (synchronous, active high) empties both registers and restarts the
// name in progress with every character set marked good.
// Top level of the name charset classifier.
module name_charset_classifier import ncc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] name_byte
   input  logic       req_tlast,  // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata   // [0] ascii_ok, [1] utf8_ok, [2] latin1_ok,
                                  // [3] cp1252_ok, [5:4] name_class, [7:6] zero
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic           out_valid_ff, out_valid_in;
   result_type     out_data_ff;
   logic           req_xfer;
   logic           drain;
   byte_class_type byte_class;
   result_type     result;

   // The held byte moves on unless it must wait for a full result register.
   assign drain      = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || drain;
   assign req_xfer   = req_tvalid && req_tready;

   // Valid bits for the input and result registers.
   always_comb begin
      in_valid_in  = req_xfer ? 1'b1 : (drain ? 1'b0 : in_valid_ff);
      out_valid_in = (drain && in_last_ff) ? 1'b1 :
                     (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   ncc_byte_decode u_decode (
      .name_byte  (in_byte_ff),
      .byte_class (byte_class)
   );

   ncc_track u_track (
      .clock      (clock),
      .reset      (reset),
      .step_valid (drain),
      .step_last  (in_last_ff),
      .byte_class (byte_class),
      .result     (result)
   );

   // Result register payload, loaded on a last byte.
   always_ff @(posedge clock) begin
      if (drain && in_last_ff) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_data_ff};

endmodule

// ===== design/ncc_checker.sv =====
// Port-level checker for the name charset classifier, with its bind.
`include "name_charset_classifier_defines.svh"

module ncc_checker import ncc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result holds its value.
   `NCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // Padding bits of the result are zero.
   `NCC_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[7:6] == 2'b00,
                   "result padding not zero")

   // A printable ASCII name passes every set and takes the ASCII class.
   `NCC_ASSERT_NOW(a_ascii_all, clock, reset, rsp_tvalid && rsp_tdata[0],
                   (rsp_tdata[3:1] == 3'b111) && (rsp_tdata[5:4] == CLASS_ASCII),
                   "ASCII name not accepted by all sets")

   // Without ASCII the class follows UTF-8, then Latin-1, then other.
   `NCC_ASSERT_NOW(a_class_order, clock, reset, rsp_tvalid && !rsp_tdata[0],
                   rsp_tdata[5:4] == (rsp_tdata[1] ? CLASS_UTF8 :
                                      (rsp_tdata[2] ? CLASS_LATIN1 : CLASS_OTHER)),
                   "class does not match flags")

   // The input is ready whenever the result side is empty or being taken.
   `NCC_ASSERT_NOW(a_req_ready, clock, reset, !rsp_tvalid || rsp_tready, req_tready,
                   "input stalled with the result side free")

endmodule

bind name_charset_classifier ncc_checker u_ncc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
